### sv/w6spc_pkg.sv
// Shared types, widths and helpers for the wheel-6 sieve prime counter.
// No dependencies; the controller, datapath and top level import this package.
`timescale 1ns / 1ps

package w6spc_pkg;

  // Field widths fixed by the stream payload.
  localparam int LIM_W    = 21;
  localparam int CNT_W    = 17;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 24;

  // Largest limit the input field can carry.
  localparam int LIM_TOP = 2 ** LIM_W - 1;

  localparam int MAX_LIMIT_DEF = 1048576;

  // Bitmap word geometry.
  localparam int WORD_BITS = 32;
  localparam int WORD_LOG  = 5;

  // Internal widths, sized for a limit below 2**LIM_W.
  localparam int P_W  = 11;  // sieving prime, stops just above sqrt(limit)
  localparam int A_W  = 9;   // prime / 3 and prime bit index
  localparam int SQ_W = 18;  // (prime / 3) squared
  localparam int MQ_W = 20;  // multiple / 3, candidate counts
  localparam int M_W  = 22;  // multiple of a prime

  // floor(x / 3) = (x * RECIP3) >> RECIP_SHIFT for every x below 2**LIM_W.
  localparam logic [LIM_W-1:0] RECIP3      = LIM_W'(1398102);
  localparam int               RECIP_SHIFT = 22;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic load;
    logic div_mul;
    logic div_fin;
    logic fill_wr;
    logic p_init;
    logic sq_mul;
    logic sq_fin;
    logic p_rd;
    logic p_adv;
    logic m_init;
    logic m_adv;
    logic m_rd;
    logic m_wr;
    logic scan_init;
    logic scan_rd;
    logic scan_acc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic p_done;
    logic p_bit;
    logic m_done;
    logic m_skip;
    logic scan_empty;
    logic out_free;
  } stat_t;

  function automatic logic [WORD_LOG:0] popcount(input logic [WORD_BITS-1:0] w);
    logic [WORD_LOG:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + (WORD_LOG + 1)'(w[i]);
    end
    return n;
  endfunction

endpackage

### sv/w6spc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module w6spc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/w6spc_ctrl.sv
// Sequencer of the wheel-6 sieve: load, divide, fill, sieve, scan and result phases.
// Depends on w6spc_pkg for the command and status structs.
`timescale 1ns / 1ps

module w6spc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  w6spc_pkg::stat_t  stat,
  output w6spc_pkg::cmd_t   cmd
);

  import w6spc_pkg::*;

  typedef enum logic [12:0] {
    IDLE   = 13'b0000000000001,
    DIV    = 13'b0000000000010,
    CNT    = 13'b0000000000100,
    FILL   = 13'b0000000001000,
    P_SQ   = 13'b0000000010000,
    P_FIN  = 13'b0000000100000,
    P_CHK  = 13'b0000001000000,
    P_TST  = 13'b0000010000000,
    M_CHK  = 13'b0000100000000,
    M_WR   = 13'b0001000000000,
    SC_CHK = 13'b0010000000000,
    SC_ACC = 13'b0100000000000,
    DONE   = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = DIV;
        end
      end
      DIV: begin
        cmd.div_mul = 1'b1;
        state_next  = CNT;
      end
      CNT: begin
        cmd.div_fin = 1'b1;
        state_next  = FILL;
      end
      FILL: begin
        cmd.fill_wr = 1'b1;
        if (stat.fill_last) begin
          cmd.p_init = 1'b1;
          state_next = P_SQ;
        end
      end
      P_SQ: begin
        cmd.sq_mul = 1'b1;
        state_next = P_FIN;
      end
      P_FIN: begin
        cmd.sq_fin = 1'b1;
        state_next = P_CHK;
      end
      P_CHK: begin
        if (stat.p_done) begin
          cmd.scan_init = 1'b1;
          state_next    = SC_CHK;
        end else begin
          cmd.p_rd   = 1'b1;
          state_next = P_TST;
        end
      end
      P_TST: begin
        if (stat.p_bit) begin
          cmd.m_init = 1'b1;
          state_next = M_CHK;
        end else begin
          cmd.p_adv  = 1'b1;
          state_next = P_SQ;
        end
      end
      M_CHK: begin
        if (stat.m_done) begin
          cmd.p_adv  = 1'b1;
          state_next = P_SQ;
        end else if (stat.m_skip) begin
          // Multiples of three have no bit in the map.
          cmd.m_adv = 1'b1;
        end else begin
          cmd.m_rd   = 1'b1;
          state_next = M_WR;
        end
      end
      M_WR: begin
        cmd.m_wr   = 1'b1;
        cmd.m_adv  = 1'b1;
        state_next = M_CHK;
      end
      SC_CHK: begin
        if (stat.scan_empty) begin
          state_next = DONE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = SC_ACC;
        end
      end
      SC_ACC: begin
        cmd.scan_acc = 1'b1;
        state_next   = SC_CHK;
      end
      DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/w6spc_dp.sv
// Datapath of the wheel-6 sieve: limit, prime and multiple registers,
// the candidate bitmap RAM, the scan counter and the result register.
// Depends on w6spc_pkg and w6spc_ram.
`timescale 1ns / 1ps

module w6spc_dp #(
  parameter int MAX_LIMIT = w6spc_pkg::MAX_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  w6spc_pkg::cmd_t               cmd,
  output w6spc_pkg::stat_t              stat,
  input  logic [w6spc_pkg::LIM_W-1:0]   limit,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [w6spc_pkg::CNT_W-1:0]   prime_count
);

  import w6spc_pkg::*;

  localparam int EFF_LIMIT = (MAX_LIMIT < LIM_TOP) ? MAX_LIMIT : LIM_TOP;
  localparam int DEPTH     = (EFF_LIMIT / 3) / WORD_BITS + 2;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LIM_W-1:0]     LIM_CAP = LIM_W'(EFF_LIMIT);
  localparam logic [WORD_BITS-1:0] ONES    = '1;

  // Request limit and the number of bitmap candidates below it.
  logic [LIM_W-1:0]   lim;
  logic [2*LIM_W-1:0] prod;
  logic [MQ_W-1:0]    cand_cnt;
  logic [MQ_W-1:0]    div_q;
  logic [MQ_W+1:0]    three_q;
  logic [1:0]         div_r;

  // Sieving prime p: bit index pidx = p/3 - 1, pside set for 6k+1.
  logic [P_W-1:0]  p;
  logic [A_W-1:0]  pidx;
  logic            pside;
  logic [A_W-1:0]  pa;
  logic [SQ_W-1:0] asq;
  logic [MQ_W-1:0] mdiv;
  logic [M_W-1:0]  psq;

  // Current multiple m, kept with its quotient and remainder by three.
  logic [M_W-1:0]  m;
  logic [MQ_W-1:0] mq;
  logic [1:0]      mr;
  logic [A_W:0]    step_q;
  logic [1:0]      step_r;
  logic [2:0]      rsum;
  logic [MQ_W-1:0] cidx;

  logic [AW-1:0]   fill_addr;
  logic [AW-1:0]   scan_addr;
  logic [MQ_W-1:0] scan_left;
  logic [MQ_W-1:0] acc;
  logic [WORD_BITS-1:0] scan_mask;
  logic [MQ_W:0]   total;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  assign div_q   = prod[2*LIM_W-1:RECIP_SHIFT];
  assign three_q = {1'b0, div_q, 1'b0} + {2'b00, div_q};
  assign div_r   = lim[1:0] - three_q[1:0];

  assign pa   = pidx + A_W'(1);
  assign psq  = {1'b0, mdiv, 1'b0} + {2'b00, mdiv} + M_W'(1);
  assign cidx = mq - MQ_W'(1);

  // Step 2p = 3*step_q + step_r; p = 3a+2 for 6k-1, p = 3a+1 for 6k+1.
  assign step_q = pside ? {pa, 1'b0} : ({pa, 1'b0} + (A_W + 1)'(1));
  assign step_r = pside ? 2'd2 : 2'd1;
  assign rsum   = {1'b0, mr} + {1'b0, step_r};

  assign scan_mask = (scan_left >= MQ_W'(WORD_BITS)) ? ONES :
                     ~(ONES << scan_left[WORD_LOG-1:0]);

  assign total = {1'b0, acc} + (MQ_W + 1)'(lim > LIM_W'(2)) + (MQ_W + 1)'(lim > LIM_W'(3));

  assign stat.fill_last  = (fill_addr == AW'(DEPTH - 1));
  assign stat.p_done     = (psq >= {1'b0, lim});
  assign stat.p_bit      = ram_rdata[pidx[WORD_LOG-1:0]];
  assign stat.m_done     = (m >= {1'b0, lim});
  assign stat.m_skip     = (mr == 2'd0);
  assign stat.scan_empty = (scan_left == '0);
  assign stat.out_free   = !out_valid || out_ready;

  always_comb begin
    ram_we    = cmd.fill_wr || cmd.m_wr;
    ram_wdata = ONES;
    if (cmd.fill_wr) begin
      ram_addr = fill_addr;
    end else if (cmd.m_rd || cmd.m_wr) begin
      ram_addr  = AW'(cidx[MQ_W-1:WORD_LOG]);
      ram_wdata = ram_rdata & ~(WORD_BITS'(1) << cidx[WORD_LOG-1:0]);
    end else if (cmd.p_rd) begin
      ram_addr = AW'(pidx[A_W-1:WORD_LOG]);
    end else begin
      ram_addr = scan_addr;
    end
  end

  w6spc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lim <= (limit > LIM_CAP) ? LIM_CAP : limit;
    end
    if (cmd.div_mul) begin
      prod <= (2 * LIM_W)'(lim) * (2 * LIM_W)'(RECIP3);
    end
    if (cmd.div_fin) begin
      // Candidates below the limit: one per value of n/3 below the limit's
      // quotient, plus the 6k+1 candidate sharing that quotient when it fits.
      if (div_q == '0) begin
        cand_cnt <= '0;
      end else begin
        cand_cnt <= div_q - MQ_W'(1) + MQ_W'(!div_q[0] && (div_r == 2'd2));
      end
      fill_addr <= '0;
    end
    if (cmd.fill_wr) begin
      fill_addr <= fill_addr + AW'(1);
    end

    if (cmd.p_init) begin
      p     <= P_W'(5);
      pidx  <= '0;
      pside <= 1'b0;
    end else if (cmd.p_adv) begin
      p     <= p + (pside ? P_W'(4) : P_W'(2));
      pidx  <= pidx + A_W'(1);
      pside <= !pside;
    end
    if (cmd.sq_mul) begin
      asq <= SQ_W'(pa) * SQ_W'(pa);
    end
    if (cmd.sq_fin) begin
      // p*p/3 is 3a*a + 2a for 6k+1 and 3a*a + 4a + 1 for 6k-1.
      mdiv <= {1'b0, asq, 1'b0} + {2'b00, asq} +
              (pside ? MQ_W'({pa, 1'b0}) : (MQ_W'({pa, 2'b00}) + MQ_W'(1)));
    end

    if (cmd.m_init) begin
      m  <= psq;
      mq <= mdiv;
      mr <= 2'd1;
    end else if (cmd.m_adv) begin
      m <= m + M_W'({p, 1'b0});
      if (rsum >= 3'd3) begin
        mr <= 2'(rsum - 3'd3);
        mq <= mq + MQ_W'(step_q) + MQ_W'(1);
      end else begin
        mr <= rsum[1:0];
        mq <= mq + MQ_W'(step_q);
      end
    end

    if (cmd.scan_init) begin
      scan_addr <= '0;
      scan_left <= cand_cnt;
      acc       <= '0;
    end else if (cmd.scan_acc) begin
      scan_addr <= scan_addr + AW'(1);
      scan_left <= (scan_left >= MQ_W'(WORD_BITS)) ? (scan_left - MQ_W'(WORD_BITS)) : '0;
      acc       <= acc + MQ_W'(popcount(ram_rdata & scan_mask));
    end

    if (cmd.out_load) begin
      prime_count <= (total > (MQ_W + 1)'(CNT_MAX)) ? CNT_MAX : CNT_W'(total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### sv/wheel6_sieve_prime_counter.sv
// Channel   Group                      Payload (lowest bit first)
// input     s_tvalid/s_tready/s_tdata  limit[20:0], zero fill [23:21]
// output    m_tvalid/m_tready/m_tdata  prime_count[16:0], zero fill [23:17]
//
// One request at a time. After a request is taken, the limit is divided by three
// and every word of the bitmap is set (DEPTH = (min(MAX_LIMIT, 2**21-1)/3)/32 + 2,
// 10924 words by default). Each candidate up to sqrt(limit) is then tested, and
// each one still marked has its multiples cleared from its square upward, skipping
// multiples of three; the bitmap words are then scanned and their set bits counted.
// The single-port bitmap RAM takes one read-modify-write per cleared multiple. Reset
// is synchronous and returns to idle.
// A result waiting on m_tready does not keep a new request from being taken;
// the finished count waits in DONE only if the output register is still full.
//
// Top level of the wheel-6 sieve prime counter.
// Depends on w6spc_pkg, w6spc_ctrl, w6spc_dp and w6spc_ram.
`timescale 1ns / 1ps

module wheel6_sieve_prime_counter #(
  parameter int MAX_LIMIT = w6spc_pkg::MAX_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [w6spc_pkg::S_DATA_W-1:0]     s_tdata,   // limit[20:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [w6spc_pkg::M_DATA_W-1:0]     m_tdata    // prime_count[16:0]
);

  import w6spc_pkg::*;

  cmd_t             cmd;
  stat_t            stat;
  logic [CNT_W-1:0] prime_count;

  w6spc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  w6spc_dp #(
    .MAX_LIMIT (MAX_LIMIT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .limit       (s_tdata[LIM_W-1:0]),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .prime_count (prime_count)
  );

  assign m_tdata = {(M_DATA_W - CNT_W)'(0), prime_count};

  // The bitmap port serves one purpose per cycle.
  a_ram_one_use: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.fill_wr, cmd.p_rd, cmd.m_rd, cmd.m_wr, cmd.scan_rd}))
    else $error("bitmap port driven by two phases at once");

  // A taken request keeps the block busy on the next cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while a sieve pass was starting");

  // A result only appears after the controller loads it.
  a_result_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("result valid without a load command");

endmodule
